[sv/kmeans_pkg.sv]
// ----------------------------------------------------------------------------
// k-means package
// Shared types and fixed constants of the k-means assign and update block.
// ----------------------------------------------------------------------------
package kmeans_pkg;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_POINT  = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int COORD_W = 16;
    localparam int IDX_W   = 4;
    localparam int PART_W  = 37;
    localparam int DIST_W  = 36;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 32;

    localparam logic [PART_W-1:0] SAT37 = {PART_W{1'b1}};
    localparam logic [DIST_W-1:0] SAT36 = {DIST_W{1'b1}};
    localparam logic [SUM_W-1:0]  SAT48 = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  SAT32 = {CNT_W{1'b1}};

    typedef struct packed {
        logic [1:0]         func;
        logic [IDX_W-1:0]   center_index;
        logic [IDX_W-1:0]   dim_index;
        logic [COORD_W-1:0] coordinate;
    } t_cmd;

endpackage

[sv/kmeans_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kmeans_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/kmeans_front.sv]
// ----------------------------------------------------------------------------
// k-means front end
// Accepts words, drops ignored ones and queues the rest in a short FIFO.
// ----------------------------------------------------------------------------
module kmeans_front #(
    parameter int NUM_CENTERS = 16,
    parameter int NUM_DIMS    = 16,
    parameter int DEPTH       = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  kmeans_pkg::t_cmd  i_cmd,
    output logic              o_valid,
    input  logic              i_pop,
    output kmeans_pkg::t_cmd  o_cmd
);
    import kmeans_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_cmd           r_q [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           keep, push, pop;

    always_comb begin
        case (i_cmd.func)
            FUNC_LOAD:   keep = ({1'b0, i_cmd.center_index} < (IDX_W+1)'(NUM_CENTERS))
                             && ({1'b0, i_cmd.dim_index} < (IDX_W+1)'(NUM_DIMS));
            FUNC_POINT:  keep = {1'b0, i_cmd.dim_index} < (IDX_W+1)'(NUM_DIMS);
            FUNC_UPDATE: keep = 1'b1;
            default:     keep = 1'b0;
        endcase
    end

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign push    = i_valid && !o_stall && keep;
    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

[sv/kmeans_back.sv]
// ----------------------------------------------------------------------------
// k-means back end
// Sequencer with one multiply-accumulate unit, a serial divider and RAMs
// for centers and sums; carries out loads, points and updates.
// ----------------------------------------------------------------------------
module kmeans_back #(
    parameter int NUM_CENTERS = 16,
    parameter int NUM_DIMS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_pop,
    input  kmeans_pkg::t_cmd                  i_cmd,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_kind,
    output logic [kmeans_pkg::IDX_W-1:0]      o_class_index,
    output logic [kmeans_pkg::DIST_W-1:0]     o_min_distance,
    output logic [kmeans_pkg::SUM_W-1:0]      o_total_distance
);
    import kmeans_pkg::*;

    localparam int CW = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
    localparam int DW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
    localparam int AW = CW + DW;
    localparam int ND = NUM_CENTERS * NUM_DIMS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIST  = 4'd1;
    localparam logic [3:0] S_DSQ   = 4'd2;
    localparam logic [3:0] S_DACC  = 4'd3;
    localparam logic [3:0] S_MIN   = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_SUMW  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_UPRD  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_UPWR  = 4'd10;
    localparam logic [3:0] S_CLR   = 4'd11;
    localparam logic [3:0] S_WAIT  = 4'd12;

    logic [3:0]          r_st;
    t_cmd                r_cmd;
    logic [CW-1:0]       r_c;
    logic [DW-1:0]       r_d;
    logic [PART_W-1:0]   r_part [NUM_CENTERS];
    logic [CNT_W-1:0]    r_cnt  [NUM_CENTERS];
    logic [COORD_W-1:0]  r_pbuf [NUM_DIMS];
    logic [COORD_W-1:0]  r_diff;
    logic [31:0]         r_sq;
    logic [PART_W-1:0]   r_best;
    logic [CW-1:0]       r_cls;
    logic [SUM_W-1:0]    r_total;
    logic [SUM_W-1:0]    r_rem;
    logic [SUM_W-1:0]    r_quo;
    logic [5:0]          r_bit;
    logic                r_ovalid;
    logic                r_okind;
    logic [IDX_W-1:0]    r_ocls;
    logic [DIST_W-1:0]   r_omin;
    logic [SUM_W-1:0]    r_ototal;
    logic [ND-1:0]       r_sval;

    // Center RAM and sum RAM.
    logic                c_we;
    logic [AW-1:0]       c_wa, c_ra;
    logic [COORD_W-1:0]  c_wd, c_rd;
    logic                s_we;
    logic [AW-1:0]       s_wa, s_ra;
    logic [SUM_W-1:0]    s_wd, s_rd, s_val;

    kmeans_ram #(.WIDTH(COORD_W), .DEPTH(1 << AW)) u_center (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd)
    );
    kmeans_ram #(.WIDTH(SUM_W), .DEPTH(1 << AW)) u_sum (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd)
    );

    logic [AW-1:0] cd_addr;
    assign cd_addr = {r_c, r_d};
    assign s_val   = r_sval[cd_addr] ? s_rd : '0;

    logic [PART_W:0]   part_sum;
    logic [SUM_W:0]    tot_sum;
    logic [SUM_W:0]    acc_sum;
    logic [SUM_W:0]    rem_try;
    logic [SUM_W-1:0]  rem_sh;
    logic              last_c, last_d;
    logic [COORD_W-1:0] mean;

    assign last_c   = (r_c == CW'(NUM_CENTERS - 1));
    assign last_d   = (r_d == DW'(NUM_DIMS - 1));
    assign part_sum = {1'b0, r_part[r_c]} + (PART_W+1)'(r_sq);
    assign tot_sum  = {1'b0, r_total} + (SUM_W+1)'((r_best > PART_W'(SAT36)) ? PART_W'(SAT36)
                                                                             : r_best);
    assign acc_sum  = {1'b0, s_val} + (SUM_W+1)'(r_pbuf[r_d]);
    assign rem_sh   = {r_rem[SUM_W-2:0], s_val[r_bit]};
    assign rem_try  = {1'b0, rem_sh} - (SUM_W+1)'(r_cnt[r_c]);
    assign mean     = (r_quo > SUM_W'(16'hFFFF)) ? 16'hFFFF : r_quo[COORD_W-1:0];

    always_comb begin
        c_we = 1'b0;
        c_wa = cd_addr;
        c_wd = r_cmd.coordinate;
        c_ra = cd_addr;
        s_we = 1'b0;
        s_wa = cd_addr;
        s_wd = acc_sum[SUM_W] ? SAT48 : acc_sum[SUM_W-1:0];
        s_ra = cd_addr;
        case (r_st)
            S_IDLE: begin
                c_we = i_valid && (i_cmd.func == FUNC_LOAD);
                c_wa = {i_cmd.center_index[CW-1:0], i_cmd.dim_index[DW-1:0]};
                c_wd = i_cmd.coordinate;
            end
            S_SUMW:  s_we = 1'b1;
            S_UPWR: begin
                c_we = 1'b1;
                c_wd = mean;
            end
            default: ;
        endcase
    end

    assign o_pop = (r_st == S_IDLE) && i_valid && !(r_ovalid && i_cmd.func != FUNC_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
            r_total  <= '0;
            r_sval   <= '0;
            for (int i = 0; i < NUM_CENTERS; i++) begin
                r_part[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        r_c   <= '0;
                        r_d   <= i_cmd.dim_index[DW-1:0];
                        if (i_cmd.func == FUNC_POINT) begin
                            r_pbuf[i_cmd.dim_index[DW-1:0]] <= i_cmd.coordinate;
                            r_st <= S_DIST;
                        end else if (i_cmd.func == FUNC_UPDATE) begin
                            r_ovalid <= 1'b1;
                            r_okind  <= 1'b1;
                            r_ocls   <= '0;
                            r_omin   <= '0;
                            r_ototal <= r_total;
                            r_d      <= '0;
                            r_st     <= S_UPRD;
                        end
                    end
                end
                S_DIST: r_st <= S_DSQ;
                S_DSQ: begin
                    r_diff <= (r_cmd.coordinate >= c_rd) ? r_cmd.coordinate - c_rd
                                                         : c_rd - r_cmd.coordinate;
                    r_st   <= S_DACC;
                end
                S_DACC: begin
                    r_sq <= r_diff * r_diff;
                    r_st <= S_WAIT;
                end
                S_WAIT: begin
                    r_part[r_c] <= part_sum[PART_W] ? SAT37 : part_sum[PART_W-1:0];
                    if (last_c) begin
                        r_c <= '0;
                        if (last_d) begin
                            r_best <= SAT37;
                            r_st   <= S_MIN;
                        end else begin
                            r_st <= S_IDLE;
                        end
                    end else begin
                        r_c  <= r_c + 1'b1;
                        r_st <= S_DIST;
                    end
                end
                S_MIN: begin
                    if (r_c == '0 || r_part[r_c] < r_best) begin
                        r_best <= r_part[r_c];
                        r_cls  <= r_c;
                    end
                    if (last_c) begin
                        r_d  <= '0;
                        r_st <= S_SUM;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_SUM: begin
                    r_c  <= r_cls;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_st <= S_SUMW;
                end
                S_SUMW: begin
                    r_sval[cd_addr] <= 1'b1;
                    if (last_d) begin
                        if (r_cnt[r_cls] != SAT32) r_cnt[r_cls] <= r_cnt[r_cls] + 1'b1;
                        r_total  <= tot_sum[SUM_W] ? SAT48 : tot_sum[SUM_W-1:0];
                        r_ovalid <= 1'b1;
                        r_okind  <= 1'b0;
                        r_ocls   <= IDX_W'(r_cls);
                        r_omin   <= (r_best > PART_W'(SAT36)) ? SAT36 : r_best[DIST_W-1:0];
                        r_ototal <= tot_sum[SUM_W] ? SAT48 : tot_sum[SUM_W-1:0];
                        for (int i = 0; i < NUM_CENTERS; i++) r_part[i] <= '0;
                        r_st <= S_IDLE;
                    end else begin
                        r_d  <= r_d + 1'b1;
                        r_st <= S_OUT;
                    end
                end
                S_UPRD: begin
                    r_rem <= '0;
                    r_quo <= '0;
                    r_bit <= 6'(SUM_W - 1);
                    r_st  <= (r_cnt[r_c] != '0) ? S_DIV : S_CLR;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (!rem_try[SUM_W]) begin
                        r_rem <= rem_try[SUM_W-1:0];
                        r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                    end
                    if (r_bit == '0) r_st <= S_UPWR;
                    else r_bit <= r_bit - 1'b1;
                end
                S_UPWR: r_st <= S_CLR;
                S_CLR: begin
                    r_sval[cd_addr] <= 1'b0;
                    if (last_d) begin
                        r_d <= '0;
                        r_cnt[r_c] <= '0;
                        if (last_c) begin
                            r_total <= '0;
                            for (int i = 0; i < NUM_CENTERS; i++) r_part[i] <= '0;
                            r_st <= S_IDLE;
                        end else begin
                            r_c  <= r_c + 1'b1;
                            r_st <= S_UPRD;
                        end
                    end else begin
                        r_d  <= r_d + 1'b1;
                        r_st <= S_UPRD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_kind           = r_okind;
    assign o_class_index    = r_ocls;
    assign o_min_distance   = r_omin;
    assign o_total_distance = r_ototal;
endmodule

[sv/kmeans_assign_and_update.sv]
// A point coordinate leaves the queue and then, for each center in turn, passes the shared MAC
// through S_DIST, S_DSQ, S_DACC and S_WAIT. The last dimension adds a minimum scan over the centers,
// a set-up step and a read and a write of the sums per dimension; the result word is then registered.
// An update divides each center and dimension sum in the serial divider; an empty center skips it.
// One word in flight at a time; a load is written as it is popped. A four-word queue parts the
// input from the sequencer. Reset (synchronous, active low) clears distances, sums and counts.
// ----------------------------------------------------------------------------
// k-means assign and update
// One Lloyd k-means pass in unsigned fixed point.
// ----------------------------------------------------------------------------
module kmeans_assign_and_update #(
    parameter int NUM_CENTERS = 16,
    parameter int NUM_DIMS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_func,
    input  logic [kmeans_pkg::IDX_W-1:0]  i_center_index,
    input  logic [kmeans_pkg::IDX_W-1:0]  i_dim_index,
    input  logic [kmeans_pkg::COORD_W-1:0] i_coordinate,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [kmeans_pkg::IDX_W-1:0]  o_class_index,
    output logic [kmeans_pkg::DIST_W-1:0] o_min_distance,
    output logic [kmeans_pkg::SUM_W-1:0]  o_total_distance
);
    import kmeans_pkg::*;

    t_cmd in_cmd, q_cmd;
    logic q_valid, q_pop;

    assign in_cmd = '{func: i_func, center_index: i_center_index,
                      dim_index: i_dim_index, coordinate: i_coordinate};

    kmeans_front #(.NUM_CENTERS(NUM_CENTERS), .NUM_DIMS(NUM_DIMS), .DEPTH(4)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(in_cmd), .o_valid(q_valid), .i_pop(q_pop), .o_cmd(q_cmd)
    );

    kmeans_back #(.NUM_CENTERS(NUM_CENTERS), .NUM_DIMS(NUM_DIMS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_pop(q_pop),
        .i_cmd(q_cmd), .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind),
        .o_class_index(o_class_index), .o_min_distance(o_min_distance),
        .o_total_distance(o_total_distance)
    );
endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// k-means assign and update testbench
// Loads centers, streams points and update commands with random gaps and
// output stalls, and checks every result word against an internal predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import kmeans_pkg::*;

    localparam int NC = 16;
    localparam int ND = 16;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic                  kind;
        logic [IDX_W-1:0]      class_index;
        logic [DIST_W-1:0]     min_distance;
        logic [SUM_W-1:0]      total_distance;
    } t_res;

    // Predictor of the clustering pass and the queue of expected result words.
    class kmeans_scoreboard;
        logic [COORD_W-1:0] centers [NC][ND];
        logic [COORD_W-1:0] point_coord [ND];
        logic [PART_W-1:0]  partial [NC];
        logic [SUM_W-1:0]   sums [NC][ND];
        logic [CNT_W-1:0]   counts [NC];
        logic [SUM_W-1:0]   total;
        t_res               pending [$];
        int                 errors;

        function new();
            errors = 0;
            total = '0;
            foreach (partial[c]) begin
                partial[c] = '0;
                counts[c] = '0;
                foreach (sums[c][d]) begin
                    sums[c][d] = '0;
                    centers[c][d] = '0;
                end
            end
            foreach (point_coord[d]) point_coord[d] = '0;
        endfunction

        function automatic logic [63:0] sat(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
            logic [63:0] s;
            s = a + b;
            return (s > lim) ? lim : s;
        endfunction

        function void note_word(logic [1:0] func, logic [3:0] ci, logic [3:0] di,
                                logic [15:0] x);
            t_res r;
            logic [63:0] best, diff, m;
            int cls;
            if (func == FUNC_LOAD) begin
                centers[ci][di] = x;
            end else if (func == FUNC_POINT) begin
                point_coord[di] = x;
                for (int c = 0; c < NC; c++) begin
                    diff = (x >= centers[c][di]) ? 64'(x - centers[c][di])
                                                 : 64'(centers[c][di] - x);
                    partial[c] = sat(partial[c], diff * diff, SAT37);
                end
                if (di == ND - 1) begin
                    best = partial[0];
                    cls = 0;
                    for (int c = 1; c < NC; c++) begin
                        if (partial[c] < best) begin
                            best = partial[c];
                            cls = c;
                        end
                    end
                    if (best > SAT36) best = SAT36;
                    for (int d = 0; d < ND; d++)
                        sums[cls][d] = sat(sums[cls][d], point_coord[d], SAT48);
                    counts[cls] = sat(counts[cls], 1, SAT32);
                    total = sat(total, best, SAT48);
                    foreach (partial[c]) partial[c] = '0;
                    r.kind = 1'b0;
                    r.class_index = cls;
                    r.min_distance = best;
                    r.total_distance = total;
                    pending.push_back(r);
                end
            end else if (func == FUNC_UPDATE) begin
                r.kind = 1'b1;
                r.class_index = '0;
                r.min_distance = '0;
                r.total_distance = total;
                pending.push_back(r);
                for (int c = 0; c < NC; c++) begin
                    if (counts[c] != 0) begin
                        for (int d = 0; d < ND; d++) begin
                            m = sums[c][d] / counts[c];
                            centers[c][d] = (m > 64'hFFFF) ? 16'hFFFF : m[15:0];
                        end
                    end
                    counts[c] = '0;
                    partial[c] = '0;
                    for (int d = 0; d < ND; d++) sums[c][d] = '0;
                end
                total = '0;
            end
        endfunction

        function void check_word(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word kind=%0d", $time, got.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, e.kind, got.kind);
                errors++;
            end
            if (got.class_index !== e.class_index) begin
                $display("%0t: class_index expected %0d actual %0d", $time,
                         e.class_index, got.class_index);
                errors++;
            end
            if (got.min_distance !== e.min_distance) begin
                $display("%0t: min_distance expected %0h actual %0h", $time,
                         e.min_distance, got.min_distance);
                errors++;
            end
            if (got.total_distance !== e.total_distance) begin
                $display("%0t: total_distance expected %0h actual %0h", $time,
                         e.total_distance, got.total_distance);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic [IDX_W-1:0]   i_center_index;
    logic [IDX_W-1:0]   i_dim_index;
    logic [COORD_W-1:0] i_coordinate;
    logic               o_valid;
    logic               i_stall;
    logic               o_kind;
    logic [IDX_W-1:0]   o_class_index;
    logic [DIST_W-1:0]  o_min_distance;
    logic [SUM_W-1:0]   o_total_distance;

    kmeans_assign_and_update dut (.*);

    kmeans_scoreboard board = new();
    longint cycles = 0;
    bit     hold_off = 0;
    bit     mean_saturate = 0;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_func = '0;
        i_center_index = '0;
        i_dim_index = '0;
        i_coordinate = '0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Input words are predicted at acceptance, results checked at acceptance.
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && i_valid && !o_stall)
            board.note_word(i_func, i_center_index, i_dim_index, i_coordinate);
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind = o_kind;
            got.class_index = o_class_index;
            got.min_distance = o_min_distance;
            got.total_distance = o_total_distance;
            board.check_word(got);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Output stall: random, with a long hold-off on request.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            n = gap_len();
            i_stall <= (n != 0);
            repeat (n == 0 ? $urandom_range(1, 20) : n) @(posedge i_clk);
        end
    end

    task automatic send_word(logic [1:0] f, logic [3:0] ci, logic [3:0] di, logic [15:0] x,
                             bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_center_index <= ci;
        i_dim_index <= di;
        i_coordinate <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_point(int lo, int hi, bit no_gap = 0);
        for (int d = 0; d < ND; d++)
            send_word(FUNC_POINT, $urandom, d, $urandom_range(lo, hi), no_gap);
    endtask

    task automatic load_centers(bit rand_vals);
        for (int c = 0; c < NC; c++)
            for (int d = 0; d < ND; d++)
                send_word(FUNC_LOAD, c, d, rand_vals ? 16'($urandom) : 16'(c * 4096));
    endtask

    initial begin
        int r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all centers equal, so ties go to index zero.
        for (int c = 0; c < NC; c++)
            for (int d = 0; d < ND; d++)
                send_word(FUNC_LOAD, c, d, 16'h0000);
        send_point(16'hFFFF, 16'hFFFF);   // largest possible distance
        send_point(0, 0);
        send_word(FUNC_UPDATE, 0, 0, 0);
        send_word(FUNC_UPDATE, 0, 0, 0);  // empty centers keep their values
        send_word(FUNC_UNUSED, 4'hF, 4'hF, 16'hFFFF);
        load_centers(0);
        send_word(FUNC_POINT, 0, 3, 16'h1234);  // dropped by the update below
        send_word(FUNC_UPDATE, 0, 0, 0);
        send_word(FUNC_POINT, 0, 5, 16'hAAAA);
        send_word(FUNC_POINT, 0, 5, 16'h5555);  // repeated dimension
        send_word(FUNC_LOAD, 4'd7, 4'd15, 16'hFFFF);  // load mid-point
        send_point(0, 65535);

        // Long output hold-off while the sender keeps offering points.
        hold_off = 1;
        repeat (8) send_point(0, 65535, 1);

        for (int n = 0; n < 480;) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_point(0, 65535);
                n += ND;
            end else if (r < 80) begin
                send_word(FUNC_POINT, 0, $urandom_range(0, ND - 2), $urandom);
                n++;
            end else if (r < 88) begin
                send_word(FUNC_LOAD, $urandom, $urandom, $urandom);
                n++;
            end else if (r < 94) begin
                send_word(FUNC_UPDATE, $urandom, $urandom, $urandom);
                n++;
            end else if (r < 97) begin
                send_word(FUNC_UNUSED, $urandom, $urandom, $urandom);
            end else begin
                load_centers(1);
                n += NC * ND;
            end
        end
        send_word(FUNC_UPDATE, 0, 0, 0);
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[kmeans_assign_and_update.f]
sv/kmeans_pkg.sv
sv/kmeans_ram.sv
sv/kmeans_front.sv
sv/kmeans_back.sv
sv/kmeans_assign_and_update.sv
test/tb_top.sv
